/* hw/rtl/nbsu_pkg.sv */
package nbsu_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int RES_BITS       = 15;
    localparam int FILL_BITS      = 4;
    localparam int COUNT_BITS     = 17;
    localparam int WIDTH_BITS     = 4;
    localparam int CAP_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 4'd7;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MIN   = 4'd1;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = 4'd8;
    localparam logic [CAP_BITS-1:0]   CAP_RESET   = 16'hFFFF;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 17'h1FFFF;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SYMBOL_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SYMBOL_CAPACITY = 2'd1;

    typedef struct packed {
        logic [BYTE_BITS-1:0] packed_byte;
        logic                 message_end;
    } byte_entry_t;

endpackage

/* hw/rtl/nbsu_front.sv */
module nbsu_front #(
    parameter int DEPTH = nbsu_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  nbsu_pkg::byte_entry_t s_entry,
    output logic                  q_valid,
    output nbsu_pkg::byte_entry_t q_entry,
    input  logic                  q_pop
);
    import nbsu_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    byte_entry_t           store_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   fill_reg, fill_next;
    logic                  push;
    logic                  pop;

    assign s_ready = (fill_reg != FULL_CNT);
    assign q_valid = (fill_reg != '0);
    assign q_entry = store_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= s_entry;
        end
    end

endmodule

/* hw/rtl/nbsu_back.sv */
module nbsu_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  nbsu_pkg::byte_entry_t               q_entry,
    output logic                                q_pop,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nbsu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nbsu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [nbsu_pkg::BYTE_BITS-1:0]      m_symbol,
    output logic                                m_run_last,
    output logic                                m_message_done,
    output logic                                m_over_capacity
);
    import nbsu_pkg::*;

    logic [WIDTH_BITS-1:0] width_reg;
    logic [CAP_BITS-1:0]   cap_reg;
    logic [RES_BITS-1:0]   res_reg, res_next;
    logic [FILL_BITS-1:0]  fill_reg, fill_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  busy_reg, busy_next;
    logic                  end_reg, end_next;

    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0]  out_symbol_reg, out_symbol_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_done_reg, out_done_next;
    logic                  out_over_reg, out_over_next;

    logic [RES_BITS-1:0]   cur_res;
    logic [FILL_BITS-1:0]  cur_fill;
    logic                  cur_end;
    logic [FILL_BITS-1:0]  rem_fill;
    logic [COUNT_BITS-1:0] count_inc;
    logic [BYTE_BITS:0]    sym_mask;
    logic                  is_last;
    logic                  go;
    logic                  width_write;
    logic [WIDTH_BITS-1:0] width_value;

    assign cfg_ready   = 1'b1;
    assign width_value = cfg_data[WIDTH_BITS-1:0];
    assign width_write = cfg_valid && (cfg_index == REG_SYMBOL_WIDTH)
                         && (width_value >= WIDTH_MIN) && (width_value <= WIDTH_MAX);

    // An idle sequencer merges the waiting byte above the pending bits in the
    // same cycle as it issues that byte's first symbol.
    always_comb begin
        cur_res  = busy_reg ? res_reg
                 : RES_BITS'(res_reg | (RES_BITS'(q_entry.packed_byte) << fill_reg));
        cur_fill = busy_reg ? fill_reg : fill_reg + FILL_BITS'(BYTE_BITS);
        cur_end  = busy_reg ? end_reg : q_entry.message_end;
        rem_fill = (cur_fill >= width_reg) ? cur_fill - width_reg : '0;
        count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        sym_mask = (BYTE_BITS+1)'((BYTE_BITS+1)'(1) << width_reg) - 1'b1;
        // Flush symbols of a final byte stop once no bits remain or the count reaches capacity.
        if (cur_end) begin
            is_last = (rem_fill == '0) || (count_inc >= COUNT_BITS'(cap_reg));
        end else begin
            is_last = (rem_fill < width_reg);
        end
        go    = (busy_reg || q_valid) && (!out_valid_reg || m_ready);
        q_pop = go && !busy_reg;
    end

    always_comb begin
        res_next        = res_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        busy_next       = busy_reg;
        end_next        = end_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_symbol_next = out_symbol_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        out_over_next   = out_over_reg;

        if (go) begin
            out_valid_next  = 1'b1;
            out_symbol_next = cur_res[BYTE_BITS-1:0] & sym_mask[BYTE_BITS-1:0];
            out_last_next   = is_last;
            out_done_next   = is_last && cur_end;
            out_over_next   = is_last && cur_end && (count_inc > COUNT_BITS'(cap_reg));
            end_next        = cur_end;
            if (is_last && cur_end) begin
                res_next   = '0;
                fill_next  = '0;
                count_next = '0;
                busy_next  = 1'b0;
            end else begin
                res_next   = (rem_fill == '0) ? '0 : cur_res >> width_reg;
                fill_next  = rem_fill;
                count_next = count_inc;
                busy_next  = !is_last;
            end
        end

        if (width_write) begin
            res_next  = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= WIDTH_RESET;
            cap_reg       <= CAP_RESET;
            res_reg       <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (width_write) begin
                width_reg <= width_value;
            end
            if (cfg_valid && (cfg_index == REG_SYMBOL_CAPACITY)) begin
                cap_reg <= cfg_data[CAP_BITS-1:0];
            end
            res_reg       <= res_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_symbol_reg <= out_symbol_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
        out_over_reg   <= out_over_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_symbol        = out_symbol_reg;
    assign m_run_last      = out_last_reg;
    assign m_message_done  = out_done_reg;
    assign m_over_capacity = out_over_reg;

endmodule

/* hw/rtl/n_bit_symbol_unpacker.sv */
// A byte accepted into the input queue reaches m_valid through the queue and output register.
// Throughput: the symbol sequencer issues one symbol per cycle unless m_ready stalls the
// output register; a byte yields at least one symbol, eight at a symbol width of one bit.
// A small input queue lets bytes be taken while the sequencer and output register are busy.
// Reset is synchronous and active low: pending bits, the symbol count and the queue clear,
// and the registers return to a width of 7 and a capacity of 65535.
module n_bit_symbol_unpacker #(
    parameter int QUEUE_DEPTH = nbsu_pkg::QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [nbsu_pkg::BYTE_BITS-1:0]      s_packed_byte,
    input  logic                                s_message_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [nbsu_pkg::BYTE_BITS-1:0]      m_symbol,
    output logic                                m_run_last,
    output logic                                m_message_done,
    output logic                                m_over_capacity,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nbsu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nbsu_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import nbsu_pkg::*;

    byte_entry_t s_entry;
    byte_entry_t q_entry;
    logic        q_valid;
    logic        q_pop;

    assign s_entry.packed_byte = s_packed_byte;
    assign s_entry.message_end = s_message_end;

    nbsu_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_entry (s_entry),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    nbsu_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_entry         (q_entry),
        .q_pop           (q_pop),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_symbol        (m_symbol),
        .m_run_last      (m_run_last),
        .m_message_done  (m_message_done),
        .m_over_capacity (m_over_capacity)
    );

endmodule
